@@ design/c8fd_pkg.sv @@
`timescale 1ns / 1ps
// c8fd_pkg: types, codes and the crc-8 byte update for the frame deframer
// no dependencies; imported by the parser, the result register, the top and the bench

package c8fd_pkg;

    // parser phases of the received stream
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } c8fd_phase_t;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] CRC_INIT      = 8'h00;
    localparam logic [7:0] START_DEFAULT = 8'd170;

    // one result item
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] frame_cmd;
        logic [7:0] frame_len;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
        logic [7:0] computed_crc;
    } c8fd_result_t;

    // crc-8, poly 0x07, msb first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

@@ design/c8fd_in_if.sv @@
`timescale 1ns / 1ps
// c8fd_in_if: valid/ready channel carrying one received byte per item
// no dependencies

interface c8fd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/c8fd_out_if.sv @@
`timescale 1ns / 1ps
// c8fd_out_if: valid/ready channel carrying one deframer result per item
// no dependencies

interface c8fd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic [7:0] computed_crc;

    modport source (output valid, output out_kind, output frame_cmd, output frame_len,
                    output byte_index, output payload_byte, output computed_crc,
                    input ready);
    modport sink   (input valid, input out_kind, input frame_cmd, input frame_len,
                    input byte_index, input payload_byte, input computed_crc,
                    output ready);
endinterface

@@ design/c8fd_in_stage.sv @@
`timescale 1ns / 1ps
// c8fd_in_stage: input register for received bytes
// depends on c8fd_in_if

module c8fd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    c8fd_in_if.sink           rx_chan,
    input  logic              consume,
    output logic              byte_valid,
    output logic [7:0]        byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // a held byte that is consumed this cycle frees the stage
    assign rx_chan.ready = !valid_reg || consume;
    assign take          = rx_chan.valid && rx_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_chan.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;
endmodule

@@ design/c8fd_parser.sv @@
`timescale 1ns / 1ps
// c8fd_parser: frame state machine, held header fields and running crc
// depends on c8fd_pkg

module c8fd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            start_byte,
    input  logic [7:0]            byte_data,
    input  logic                  consume,
    output logic                  has_result,
    output c8fd_pkg::c8fd_result_t result
);
    import c8fd_pkg::*;

    c8fd_phase_t phase_reg;
    c8fd_phase_t phase_next;
    logic [7:0]  cmd_reg;
    logic [7:0]  cmd_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic [7:0]  count_inc;
    logic [7:0]  crc_upd;

    assign count_inc = count_reg + 8'd1;
    assign crc_upd   = crc8_byte(crc_reg, byte_data);

    // next phase
    always_comb
    begin
        case (phase_reg)
            PH_CMD:  phase_next = PH_LEN;
            PH_LEN:  phase_next = (byte_data != 8'd0) ? PH_DATA : PH_CRC;
            PH_DATA: phase_next = (count_inc >= len_reg) ? PH_CRC : PH_DATA;
            PH_CRC:  phase_next = PH_HUNT;
            default: phase_next = (byte_data == start_byte) ? PH_CMD : PH_HUNT;
        endcase
    end

    // header fields, count and crc
    always_comb
    begin
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        case (phase_reg)
            PH_CMD:
            begin
                cmd_next = byte_data;
            end
            PH_LEN:
            begin
                len_next   = byte_data;
                count_next = 8'd0;
                crc_next   = CRC_INIT;
            end
            PH_DATA:
            begin
                count_next = count_inc;
                crc_next   = crc_upd;
            end
            default:
            begin
                cmd_next = cmd_reg;
            end
        endcase
    end

    // result of the byte in hand
    always_comb
    begin
        has_result          = 1'b0;
        result.out_kind     = KIND_PAYLOAD;
        result.frame_cmd    = cmd_reg;
        result.frame_len    = len_reg;
        result.byte_index   = 8'd0;
        result.payload_byte = 8'd0;
        result.computed_crc = 8'd0;
        case (phase_reg)
            PH_DATA:
            begin
                has_result          = 1'b1;
                result.byte_index   = count_reg;
                result.payload_byte = byte_data;
            end
            PH_CRC:
            begin
                has_result          = 1'b1;
                result.out_kind     = (byte_data == crc_reg) ? KIND_GOOD : KIND_BAD;
                result.computed_crc = crc_reg;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            crc_reg   <= CRC_INIT;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end
endmodule

@@ design/c8fd_out_reg.sv @@
`timescale 1ns / 1ps
// c8fd_out_reg: result register driving the output channel
// depends on c8fd_pkg and c8fd_out_if

module c8fd_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  c8fd_pkg::c8fd_result_t result,
    output logic                  can_load,
    c8fd_out_if.source            res_chan
);
    import c8fd_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    c8fd_result_t data_reg;

    // free when empty or when the held item leaves this cycle
    assign can_load = !valid_reg || res_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res_chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res_chan.valid        = valid_reg;
    assign res_chan.out_kind     = data_reg.out_kind;
    assign res_chan.frame_cmd    = data_reg.frame_cmd;
    assign res_chan.frame_len    = data_reg.frame_len;
    assign res_chan.byte_index   = data_reg.byte_index;
    assign res_chan.payload_byte = data_reg.payload_byte;
    assign res_chan.computed_crc = data_reg.computed_crc;
endmodule

@@ design/crc8_frame_deframer.sv @@
`timescale 1ns / 1ps
// crc8_frame_deframer: receive-side frame parser with crc-8 check
// depends on c8fd_pkg, c8fd_in_if, c8fd_out_if, c8fd_in_stage, c8fd_parser, c8fd_out_reg
//
// usage
//   rx_chan takes one received byte per item (valid/ready). the block hunts for
//   the start byte, then reads command, length, payload and crc bytes
//   res_chan gives one item per payload byte (kind payload, with command,
//   length, index and byte) and one frame-end item per frame (kind good or
//   mismatch, with the crc computed over the payload); other bytes give no item
//   cfg_we/cfg_wdata write the start byte value; write only while idle
//   path: input register, then parse logic into the result register
//   throughput: one byte per cycle while res_chan does not stall; the crc
//   update is one unrolled byte step between the input register and the
//   parser's crc register
//   reset clears the parser to hunting, the start byte to 0xaa and both
//   pipeline registers to empty
//   when res_chan stalls, the held result stays; one more byte may sit in the
//   input register, and rx_chan.ready drops once a byte that needs a result
//   cannot move on. bytes without a result keep flowing during a stall

module crc8_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    c8fd_in_if.sink    rx_chan,
    c8fd_out_if.source res_chan
);
    import c8fd_pkg::*;

    logic [7:0]   start_byte_reg;
    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         has_result;
    logic         can_load;
    logic         consume;
    c8fd_result_t result;

    // start-of-frame value register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_DEFAULT;
        end
        else if (cfg_we)
        begin
            start_byte_reg <= cfg_wdata;
        end
    end

    // held byte moves on unless it needs a result slot that is still full
    assign consume = byte_valid && (!has_result || can_load);

    c8fd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_chan    (rx_chan),
        .consume    (consume),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    c8fd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_byte (start_byte_reg),
        .byte_data  (byte_data),
        .consume    (consume),
        .has_result (has_result),
        .result     (result)
    );

    c8fd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume && has_result),
        .result   (result),
        .can_load (can_load),
        .res_chan (res_chan)
    );
endmodule

@@ sim/crc8_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
// crc8_frame_deframer_tb: self-checking bench for the crc-8 frame deframer
// depends on c8fd_pkg, c8fd_in_if, c8fd_out_if and crc8_frame_deframer

module crc8_frame_deframer_tb;
    import c8fd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 6;       // covers the two-stage pipeline and then some
    localparam int PHASE_BYTES  = 450;     // frame bytes per random phase

    // tracks the parser on the side and holds the results it still waits for
    class deframe_scoreboard;
        logic [7:0]   start_byte;
        c8fd_phase_t  phase;
        logic [7:0]   cmd;
        logic [7:0]   len;
        logic [7:0]   count;
        logic [7:0]   crc;
        c8fd_result_t awaited_items[$];
        int           mismatches;

        function new();
            start_byte = START_DEFAULT;
            phase      = PH_HUNT;
            cmd        = 8'h00;
            len        = 8'h00;
            count      = 8'h00;
            crc        = CRC_INIT;
            mismatches = 0;
        endfunction

        // bit-serial form of the crc: feed one message bit at a time, msb first
        static function logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ b[i];
                r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void set_start_byte(input logic [7:0] v);
            start_byte = v;
        endfunction

        function int awaited();
            return awaited_items.size();
        endfunction

        // one accepted rx item: advance the parser, queue any result it causes
        function void take_rx_byte(input logic [7:0] b);
            c8fd_result_t r;
            r.frame_cmd = cmd;
            r.frame_len = len;
            case (phase)
                PH_CMD:
                begin
                    cmd   = b;
                    phase = PH_LEN;
                end
                PH_LEN:
                begin
                    len   = b;
                    count = 8'h00;
                    crc   = CRC_INIT;
                    phase = (b != 8'h00) ? PH_DATA : PH_CRC;
                end
                PH_DATA:
                begin
                    crc            = crc8_next(crc, b);
                    r.out_kind     = KIND_PAYLOAD;
                    r.byte_index   = count;
                    r.payload_byte = b;
                    r.computed_crc = 8'h00;
                    awaited_items.push_back(r);
                    count = count + 8'd1;
                    if (count >= len)
                    begin
                        phase = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    r.out_kind     = (b == crc) ? KIND_GOOD : KIND_BAD;
                    r.byte_index   = 8'h00;
                    r.payload_byte = 8'h00;
                    r.computed_crc = crc;
                    awaited_items.push_back(r);
                    phase = PH_HUNT;
                end
                default:
                begin
                    phase = (b == start_byte) ? PH_CMD : PH_HUNT;
                end
            endcase
        endfunction

        function void compare_field(input string name, input logic [7:0] e,
                                    input logic [7:0] a);
            if (a !== e)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                mismatches++;
            end
        endfunction

        // one accepted result item against the oldest one waiting
        function void check_result(input c8fd_result_t got);
            c8fd_result_t exp;
            if (awaited_items.size() == 0)
            begin
                $error("out_kind: expected no item, got %0h", got.out_kind);
                mismatches++;
                return;
            end
            exp = awaited_items.pop_front();
            compare_field("out_kind",     {6'd0, exp.out_kind}, {6'd0, got.out_kind});
            compare_field("frame_cmd",    exp.frame_cmd,    got.frame_cmd);
            compare_field("frame_len",    exp.frame_len,    got.frame_len);
            compare_field("byte_index",   exp.byte_index,   got.byte_index);
            compare_field("payload_byte", exp.payload_byte, got.payload_byte);
            compare_field("computed_crc", exp.computed_crc, got.computed_crc);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         cycles;

    // calm stretches: the side draws no idle cycles while its flag is set
    bit         rx_calm;
    bit         res_calm;

    deframe_scoreboard deframe_sb;

    c8fd_in_if  rx_if ();
    c8fd_out_if res_if ();

    crc8_frame_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx_chan   (rx_if),
        .res_chan  (res_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // flip the calm flags now and then so gaps hit every phase of a frame,
    // with some stretches running at full rate
    initial
    begin
        rx_calm  = 1'b0;
        res_calm = 1'b0;
        forever
        begin
            repeat (200) @(posedge clk);
            rx_calm  = ($urandom_range(0, 3) == 0);
            res_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // hard stop: a hung handshake ends here
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------- rx side

    // offer one byte, hold it until the block takes it; valid stays high
    // across back-to-back items so it is never dropped and raised in one step
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = rx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!rx_if.ready);
        deframe_sb.take_rx_byte(b);
    endtask

    // a whole frame: start, command, length, payload, then the crc byte,
    // xor'ed with crc_flip so a nonzero flip makes a mismatch
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] payload[$],
                              input logic [7:0] crc_flip);
        logic [7:0] c;
        c = CRC_INIT;
        send_byte(deframe_sb.start_byte);
        send_byte(cmd);
        send_byte(8'(payload.size()));
        foreach (payload[i])
        begin
            c = deframe_scoreboard::crc8_next(c, payload[i]);
            send_byte(payload[i]);
        end
        send_byte(c ^ crc_flip);
    endtask

    // random traffic: mostly well-formed frames with random content,
    // plus line noise between frames and frames cut short by a fresh start
    task automatic run_random(input int n_bytes, input bit with_long_frame);
        logic [7:0] payload[$];
        logic [7:0] flip;
        int         sent;
        int         n;
        int         pick;
        sent = 0;
        while (sent < n_bytes)
        begin
            // noise while hunting
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end

            // broken frame: start byte and a few bytes, then the next frame
            // runs into it
            if ($urandom_range(0, 19) == 0)
            begin
                n = $urandom_range(1, 6);
                send_byte(deframe_sb.start_byte);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                sent += n + 1;
            end

            // length mostly short, sometimes anything, rarely the maximum
            pick = $urandom_range(0, 99);
            if (with_long_frame || pick == 0)
            begin
                n = 255;
                with_long_frame = 1'b0;
            end
            else if (pick < 8)
            begin
                n = $urandom_range(0, 255);
            end
            else
            begin
                n = $urandom_range(0, 8);
            end

            payload.delete();
            repeat (n) payload.push_back(8'($urandom_range(0, 255)));
            flip = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
            send_frame(8'($urandom_range(0, 255)), payload, flip);
            sent += n + 4;
        end
    endtask

    // let every awaited result arrive, then let the pipeline run empty
    // (hunt, command and length bytes give no result and may still be in it)
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (deframe_sb.awaited() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // start byte write, only with the block idle
    task automatic write_start_byte(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        deframe_sb.set_start_byte(v);
    endtask

    // ---------------------------------------------------------------- result side

    // draw a stall before every item, then take whatever comes and check it
    initial
    begin
        int           stall;
        c8fd_result_t got;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = res_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!res_if.valid);
            got.out_kind     = res_if.out_kind;
            got.frame_cmd    = res_if.frame_cmd;
            got.frame_len    = res_if.frame_len;
            got.byte_index   = res_if.byte_index;
            got.payload_byte = res_if.payload_byte;
            got.computed_crc = res_if.computed_crc;
            deframe_sb.check_result(got);
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        logic [7:0] payload[$];
        deframe_sb = new();

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 8'h00;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, start byte at its reset value
        // bytes while hunting are dropped
        send_byte(8'h00);
        send_byte(8'hFF);

        // zero length, crc byte 0 is good
        payload.delete();
        send_frame(8'hFF, payload, 8'h00);

        // zero length, nonzero crc byte is a mismatch
        send_frame(8'h00, payload, 8'h5A);

        // start byte as command and inside the payload: no resync
        payload = '{START_DEFAULT, 8'hFF, 8'h00};
        send_frame(START_DEFAULT, payload, 8'h00);

        // one-byte payload with a wrong crc
        payload = '{8'h80};
        send_frame(8'h01, payload, 8'h01);

        // random phases: reset start byte, then 0x00, 0xff and a random value
        run_random(PHASE_BYTES, 1'b1);
        drain();

        write_start_byte(8'h00);
        run_random(PHASE_BYTES, 1'b0);
        drain();

        write_start_byte(8'hFF);
        run_random(PHASE_BYTES, 1'b0);
        drain();

        write_start_byte(8'($urandom_range(1, 254)));
        run_random(PHASE_BYTES, 1'b0);
        drain();

        if (deframe_sb.mismatches == 0 && deframe_sb.awaited() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
